// ===== rtl/got_pkg.sv =====
// types, constants and button and axis helper functions for the gamepad override transform
package got_pkg;

    localparam int AXIS_W = 16;
    localparam int BTN_W  = 16;
    localparam int MODE_W = 12;
    localparam int DIR_W  = 8;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 2 * AXIS_W;
    localparam int FRAC_W = 12;

    localparam logic signed [AXIS_W-1:0] AXIS_MIN = 16'sh8000;
    localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sh7fff;
    localparam logic signed [AXIS_W-1:0] GAIN_UNITY = 16'sh1000;

    localparam logic [BTN_W-1:0] BTN_A = 16'h1000;
    localparam logic [BTN_W-1:0] BTN_B = 16'h2000;
    localparam logic [BTN_W-1:0] BTN_X = 16'h4000;
    localparam logic [BTN_W-1:0] BTN_Y = 16'h8000;

    localparam int MODE_SWAP_AB  = 0;
    localparam int MODE_SWAP_XY  = 1;
    localparam int MODE_INV_BASE = 2;
    localparam int MODE_SCALE_L  = 6;
    localparam int MODE_SCALE_R  = 7;
    localparam int MODE_FRC_BASE = 8;

    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_HOLD_BUTTONS  = 3'd0,
        CFG_BLOCK_BUTTONS = 3'd1,
        CFG_MODE_FLAGS    = 3'd2,
        CFG_SCALE_LEFT    = 3'd3,
        CFG_SCALE_RIGHT   = 3'd4,
        CFG_BLOCKED_DIRS  = 3'd5,
        CFG_FORCED_LEFT   = 3'd6,
        CFG_FORCED_RIGHT  = 3'd7
    } t_cfg_idx;

    typedef logic signed [AXIS_W-1:0] t_axis;

    function automatic logic [BTN_W-1:0] swap_pair(input logic [BTN_W-1:0] b,
                                                   input logic [BTN_W-1:0] m1,
                                                   input logic [BTN_W-1:0] m2);
        logic [BTN_W-1:0] r;
        r = b & ~(m1 | m2);
        if ((b & m1) != '0) r = r | m2;
        if ((b & m2) != '0) r = r | m1;
        return r;
    endfunction

    function automatic t_axis flip_axis(input t_axis v);
        t_axis r;
        if (v == AXIS_MIN) r = AXIS_MAX;
        else               r = -v;
        return r;
    endfunction

    function automatic t_axis gain_axis(input t_axis v, input t_axis g);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        t_axis r;
        p = PROD_W'(v) * PROD_W'(g);
        if (p < 0) p = p + PROD_W'((1 << FRAC_W) - 1);
        q = p >>> FRAC_W;
        if (q > PROD_W'(AXIS_MAX))       r = AXIS_MAX;
        else if (q < $signed(PROD_W'(AXIS_MIN)) && q[PROD_W-1]) r = AXIS_MIN;
        else                             r = q[AXIS_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/gamepad_override_transform_core.sv =====
// gamepad override transform: one override layer applied to each report
// each beat passes through the input register, then the result register
// throughput: one report per cycle while the output is not stalled, set by the two-register
//   pipeline with four parallel 16x16 multipliers in the single logic pass between the registers
// reset: synchronous active low; clears both stage valids, config registers return
//   to zero except the two stick gains, which return to unity
module gamepad_override_transform_core
    import got_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [BTN_W-1:0]         i_buttons_in,
    input  logic signed [AXIS_W-1:0] i_left_x_in,
    input  logic signed [AXIS_W-1:0] i_left_y_in,
    input  logic signed [AXIS_W-1:0] i_right_x_in,
    input  logic signed [AXIS_W-1:0] i_right_y_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [BTN_W-1:0]         o_buttons_out,
    output logic signed [AXIS_W-1:0] o_left_x_out,
    output logic signed [AXIS_W-1:0] o_left_y_out,
    output logic signed [AXIS_W-1:0] o_right_x_out,
    output logic signed [AXIS_W-1:0] o_right_y_out
);

    logic [BTN_W-1:0]  r_hold;
    logic [BTN_W-1:0]  r_block;
    logic [MODE_W-1:0] r_mode;
    t_axis             r_gain_l;
    t_axis             r_gain_r;
    logic [DIR_W-1:0]  r_dirs;
    logic [CFG_W-1:0]  r_frc_l;
    logic [CFG_W-1:0]  r_frc_r;

    logic              r_s1_valid;
    logic [BTN_W-1:0]  r_s1_btn;
    t_axis             r_s1_ax [4];

    logic              r_o_valid;
    logic [BTN_W-1:0]  r_o_btn;
    t_axis             r_o_ax [4];

    logic              s2_ready;
    logic              s1_adv;
    logic [BTN_W-1:0]  n_btn;
    t_axis             n_ax [4];
    t_axis             frc_val [4];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold   <= '0;
            r_block  <= '0;
            r_mode   <= '0;
            r_gain_l <= GAIN_UNITY;
            r_gain_r <= GAIN_UNITY;
            r_dirs   <= '0;
            r_frc_l  <= '0;
            r_frc_r  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HOLD_BUTTONS:  r_hold   <= i_cfg_data[BTN_W-1:0];
                CFG_BLOCK_BUTTONS: r_block  <= i_cfg_data[BTN_W-1:0];
                CFG_MODE_FLAGS:    r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_SCALE_LEFT:    r_gain_l <= i_cfg_data[AXIS_W-1:0];
                CFG_SCALE_RIGHT:   r_gain_r <= i_cfg_data[AXIS_W-1:0];
                CFG_BLOCKED_DIRS:  r_dirs   <= i_cfg_data[DIR_W-1:0];
                CFG_FORCED_LEFT:   r_frc_l  <= i_cfg_data;
                CFG_FORCED_RIGHT:  r_frc_r  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s2_ready   = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s2_ready;
    assign s1_adv     = r_s1_valid && s2_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_btn   <= i_buttons_in;
            r_s1_ax[0] <= i_left_x_in;
            r_s1_ax[1] <= i_left_y_in;
            r_s1_ax[2] <= i_right_x_in;
            r_s1_ax[3] <= i_right_y_in;
        end
    end

    assign frc_val[0] = r_frc_l[AXIS_W-1:0];
    assign frc_val[1] = r_frc_l[CFG_W-1:AXIS_W];
    assign frc_val[2] = r_frc_r[AXIS_W-1:0];
    assign frc_val[3] = r_frc_r[CFG_W-1:AXIS_W];

    // transform pass
    always_comb begin
        logic [BTN_W-1:0] b;
        logic [3:0]       d;
        b = (r_s1_btn | r_hold) & ~r_block;
        if (r_mode[MODE_SWAP_AB]) b = swap_pair(b, BTN_A, BTN_B);
        if (r_mode[MODE_SWAP_XY]) b = swap_pair(b, BTN_X, BTN_Y);
        n_btn = b;

        for (int i = 0; i < 4; i++) begin
            n_ax[i] = r_s1_ax[i];
            if (r_mode[MODE_INV_BASE + i]) n_ax[i] = flip_axis(n_ax[i]);
        end

        if (r_mode[MODE_SCALE_L]) begin
            n_ax[0] = gain_axis(n_ax[0], r_gain_l);
            n_ax[1] = gain_axis(n_ax[1], r_gain_l);
        end
        if (r_mode[MODE_SCALE_R]) begin
            n_ax[2] = gain_axis(n_ax[2], r_gain_r);
            n_ax[3] = gain_axis(n_ax[3], r_gain_r);
        end

        for (int s = 0; s < 2; s++) begin
            d = r_dirs[4*s +: 4];
            if (d[DIR_UP]    && n_ax[2*s+1] > 0) n_ax[2*s+1] = '0;
            if (d[DIR_DOWN]  && n_ax[2*s+1] < 0) n_ax[2*s+1] = '0;
            if (d[DIR_LEFT]  && n_ax[2*s]   < 0) n_ax[2*s]   = '0;
            if (d[DIR_RIGHT] && n_ax[2*s]   > 0) n_ax[2*s]   = '0;
        end

        for (int i = 0; i < 4; i++) begin
            if (r_mode[MODE_FRC_BASE + i]) n_ax[i] = frc_val[i];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_btn <= n_btn;
            for (int i = 0; i < 4; i++) r_o_ax[i] <= n_ax[i];
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_buttons_out = r_o_btn;
    assign o_left_x_out  = r_o_ax[0];
    assign o_left_y_out  = r_o_ax[1];
    assign o_right_x_out = r_o_ax[2];
    assign o_right_y_out = r_o_ax[3];

endmodule

// ===== rtl/got_checker.sv =====
// port-level checker for the gamepad override transform, bound to the transform core
module got_checker
    import got_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     o_in_ready,
    input  logic [BTN_W-1:0]         i_buttons_in,
    input  logic signed [AXIS_W-1:0] i_left_x_in,
    input  logic signed [AXIS_W-1:0] i_left_y_in,
    input  logic signed [AXIS_W-1:0] i_right_x_in,
    input  logic signed [AXIS_W-1:0] i_right_y_in,
    input  logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  logic [BTN_W-1:0]         o_buttons_out,
    input  logic signed [AXIS_W-1:0] o_left_x_out,
    input  logic signed [AXIS_W-1:0] o_left_y_out,
    input  logic signed [AXIS_W-1:0] o_right_x_out,
    input  logic signed [AXIS_W-1:0] o_right_y_out
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_buttons_out)
            && $stable(o_left_x_out) && $stable(o_left_y_out)
            && $stable(o_right_x_out) && $stable(o_right_y_out))
        else $error("result beat changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // an empty output side never stalls the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // an accepted beat shows up as a result beat after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##2 o_out_valid)
        else $error("no result beat two cycles after input beat");

endmodule

bind gamepad_override_transform_core got_checker u_got_checker (.*);
